/* hdl/bdp_pkg.sv */
// Shared types and constants for the double press pump timer.
package bdp_pkg;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_BOUNCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RUN    = 2'd2;

	// Register reset values
	localparam logic [15:0] BOUNCE_RST = 16'd50;
	localparam logic [15:0] WINDOW_RST = 16'd400;
	localparam logic [31:0] RUN_RST    = 32'd600000;

	typedef struct packed {
		logic [15:0] bounce_ms;
		logic [15:0] double_window_ms;
		logic [31:0] run_duration_ms;
	} cfg_t;

	typedef struct packed {
		logic pump_on;
		logic switched_on;
		logic switched_off_press;
		logic timed_out;
	} result_t;

endpackage

/* hdl/bdp_cfg.sv */
// Configuration register file for the double press pump timer.
module bdp_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bdp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                    cfg_data,
	output bdp_pkg::cfg_t                  cfg
);
	import bdp_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bounce_ms        <= BOUNCE_RST;
			cfg_q.double_window_ms <= WINDOW_RST;
			cfg_q.run_duration_ms  <= RUN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_BOUNCE: cfg_q.bounce_ms        <= cfg_data[15:0];
				CFG_WINDOW: cfg_q.double_window_ms <= cfg_data[15:0];
				CFG_RUN:    cfg_q.run_duration_ms  <= cfg_data;
				default:    ;
			endcase
		end
	end

endmodule

/* hdl/bdp_step.sv */
// Button edge, double press and run timer state with its one-sample update.
module bdp_step (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic             button,
	input  logic [31:0]      now_ms,
	input  bdp_pkg::cfg_t    cfg,
	output bdp_pkg::result_t res
);
	import bdp_pkg::*;

	logic        prev_button_q;
	logic [31:0] press_time_q;
	logic [31:0] release_time_q;
	logic        double_seen_q;
	logic        armed_on_q;
	logic        pump_running_q;
	logic [31:0] run_start_q;

	logic [31:0] run_el, press_el, rel_el;
	logic        tmo, rise, fall, long_press, rel_upd, in_window, quiet;
	logic        dbl_mid, pump_mid, on_ev, off_ev;
	logic        armed_nx, double_nx, pump_nx;

	// All elapsed times come from the state before this sample; a time stamp
	// written in this sample would give zero elapsed, handled by masking.
	always_comb begin
		run_el     = now_ms - run_start_q;
		press_el   = now_ms - press_time_q;
		rel_el     = now_ms - release_time_q;
		tmo        = pump_running_q && (run_el >= cfg.run_duration_ms);
		rise       = button && !prev_button_q;
		fall       = !button && prev_button_q;
		long_press = press_el > {16'd0, cfg.bounce_ms};
		in_window  = rel_el < {16'd0, cfg.double_window_ms};
		quiet      = rel_el > {16'd0, cfg.double_window_ms};
		rel_upd    = fall && long_press;
		dbl_mid    = double_seen_q || (rel_upd && in_window);
		pump_mid   = pump_running_q && !tmo;
		on_ev      = !armed_on_q && dbl_mid && quiet && !rel_upd;
		off_ev     = armed_on_q && dbl_mid && button && long_press && !rise;
		armed_nx   = on_ev ? 1'b1 : (off_ev ? 1'b0 : armed_on_q);
		double_nx  = off_ev ? 1'b0 : dbl_mid;
		pump_nx    = on_ev ? 1'b1 : (off_ev ? 1'b0 : pump_mid);

		res.pump_on            = pump_nx;
		res.switched_on        = on_ev;
		res.switched_off_press = off_ev;
		res.timed_out          = tmo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_button_q  <= 1'b0;
			press_time_q   <= '0;
			release_time_q <= '0;
			double_seen_q  <= 1'b0;
			armed_on_q     <= 1'b0;
			pump_running_q <= 1'b0;
			run_start_q    <= '0;
		end else if (fire) begin
			prev_button_q  <= button;
			double_seen_q  <= double_nx;
			armed_on_q     <= armed_nx;
			pump_running_q <= pump_nx;
			if (rise)
				press_time_q <= now_ms;
			if (rel_upd)
				release_time_q <= now_ms;
			if (on_ev)
				run_start_q <= now_ms;
		end
	end

	// Arming only ever happens together with a pending double press.
	a_armed_needs_double: assert property (@(posedge clk) disable iff (!arst_n)
		armed_on_q |-> double_seen_q)
		else $error("armed without a double press");

	// The pump never runs while disarmed.
	a_run_needs_arm: assert property (@(posedge clk) disable iff (!arst_n)
		pump_running_q |-> armed_on_q)
		else $error("pump running while not armed");

	// A switch-on stamps the run start with the sample time.
	a_on_stamps_start: assert property (@(posedge clk) disable iff (!arst_n)
		fire && on_ev |=> pump_running_q && run_start_q == $past(now_ms))
		else $error("switch-on did not start the run timer");

endmodule

/* hdl/button_double_press_pump_timer_core.sv */
// Top level of the double press pump timer: input register, step logic, result register.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------------
//  in      | in_valid / in_ready  | button, now_ms
//  out     | out_valid / out_ready| pump_on, switched_on, switched_off_press, timed_out
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A sample accepted into the input register is stepped into the result register
// once that register is free or being drained, and its result is then offered
// on the out channel.
// One sample is accepted every cycle while the result side drains; the step logic
// is a single pass of parallel 32-bit subtract-compares feeding the state update.
// Reset clears the control state and loads the register defaults; no sweep.
// A stalled result holds the result register and then the input register;
// the input side still takes an item while the input register is empty.
// Configuration writes are taken every cycle.
module button_double_press_pump_timer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          button,
	input  logic [31:0]                   now_ms,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          pump_on,
	output logic                          switched_on,
	output logic                          switched_off_press,
	output logic                          timed_out,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bdp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);
	import bdp_pkg::*;

	cfg_t        cfg;
	result_t     res;
	result_t     res_q;
	logic        valid_s1;
	logic        button_s1;
	logic [31:0] now_s1;
	logic        fire;

	// Step the state when a sample sits in the input register and the
	// result register is free or being drained this cycle.
	assign fire     = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || fire;

	bdp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bdp_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.button (button_s1),
		.now_ms (now_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Input register: load a new item whenever there is room.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			button_s1 <= button;
			now_s1    <= now_ms;
		end
	end

	// Result register: capture on a step, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (fire) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			res_q <= res;
	end

	assign pump_on            = res_q.pump_on;
	assign switched_on        = res_q.switched_on;
	assign switched_off_press = res_q.switched_off_press;
	assign timed_out          = res_q.timed_out;

	// A switch-on always leaves the pump running.
	a_on_runs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && switched_on |-> pump_on)
		else $error("switch-on with pump off");

	// Switch-on and press switch-off never share a result.
	a_on_off_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(switched_on && switched_off_press))
		else $error("switch-on and switch-off in one result");

	// An off action without a switch-on leaves the pump stopped.
	a_off_stops: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (switched_off_press || (timed_out && !switched_on)) |-> !pump_on)
		else $error("pump still on after switch-off");

	// An empty input register always takes the next item.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled while input register empty");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the double press pump timer core.
`timescale 1ns / 100ps

module testbench;
	import bdp_pkg::*;

	// Unused register index: a write to it must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned PHASES = 8;
	localparam int unsigned ITEMS_PER_PHASE = 200;

	// Tracks the pump state and holds the outcomes the core still owes.
	class pump_tracker;
		logic [31:0] bounce_ms;
		logic [31:0] window_ms;
		logic [31:0] run_ms;
		logic        prev_btn;
		logic [31:0] press_t;
		logic [31:0] release_t;
		logic        double_seen;
		logic        armed;
		logic        running;
		logic [31:0] run_start;
		result_t     owed_outcomes[$];
		int          errors;

		function new();
			bounce_ms   = {16'h0, BOUNCE_RST};
			window_ms   = {16'h0, WINDOW_RST};
			run_ms      = RUN_RST;
			prev_btn    = 1'b0;
			press_t     = '0;
			release_t   = '0;
			double_seen = 1'b0;
			armed       = 1'b0;
			running     = 1'b0;
			run_start   = '0;
			errors      = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
			case (idx)
				CFG_BOUNCE: bounce_ms = {16'h0, data[15:0]};
				CFG_WINDOW: window_ms = {16'h0, data[15:0]};
				CFG_RUN:    run_ms    = data;
				default:    ;
			endcase
		endfunction

		// Advance the pump state by one sample and queue the outcome.
		function void take_sample(logic btn, logic [31:0] t);
			result_t outcome;
			outcome = '0;
			if (running && (t - run_start) >= run_ms) begin
				running = 1'b0;
				outcome.timed_out = 1'b1;
			end
			if (btn && !prev_btn)
				press_t = t;
			if (!btn && prev_btn && (t - press_t) > bounce_ms) begin
				if ((t - release_t) < window_ms)
					double_seen = 1'b1;
				release_t = t;
			end
			prev_btn = btn;
			if (!armed && double_seen && (t - release_t) > window_ms) begin
				armed     = 1'b1;
				running   = 1'b1;
				run_start = t;
				outcome.switched_on = 1'b1;
			end else if (armed && double_seen && btn && (t - press_t) > bounce_ms) begin
				double_seen = 1'b0;
				armed       = 1'b0;
				running     = 1'b0;
				outcome.switched_off_press = 1'b1;
			end
			outcome.pump_on = running;
			owed_outcomes.push_back(outcome);
		endfunction

		function void match_result(result_t got);
			result_t want;
			if (owed_outcomes.size() == 0) begin
				$error("result with no sample outstanding: %b", got);
				errors++;
				return;
			end
			want = owed_outcomes.pop_front();
			if (got.pump_on !== want.pump_on) begin
				$error("pump_on: expected %0b, got %0b", want.pump_on, got.pump_on);
				errors++;
			end
			if (got.switched_on !== want.switched_on) begin
				$error("switched_on: expected %0b, got %0b", want.switched_on, got.switched_on);
				errors++;
			end
			if (got.switched_off_press !== want.switched_off_press) begin
				$error("switched_off_press: expected %0b, got %0b",
					want.switched_off_press, got.switched_off_press);
				errors++;
			end
			if (got.timed_out !== want.timed_out) begin
				$error("timed_out: expected %0b, got %0b", want.timed_out, got.timed_out);
				errors++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 button = 1'b0;
	logic [31:0]          now_ms = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 pump_on;
	logic                 switched_on;
	logic                 switched_off_press;
	logic                 timed_out;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_BOUNCE;
	logic [31:0]          cfg_data = '0;

	pump_tracker sb;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned n_sent = 0;
	int unsigned cycle_count = 0;
	logic [31:0] t_ms = '0;	// running stimulus time

	button_double_press_pump_timer_core u_top (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.button             (button),
		.now_ms             (now_ms),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.pump_on            (pump_on),
		.switched_on        (switched_on),
		.switched_off_press (switched_off_press),
		.timed_out          (timed_out),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Stall the result side at random, at the rate set for the phase.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Check every result taken at this edge against the oldest owed outcome.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.match_result({pump_on, switched_on, switched_off_press, timed_out});
	end

	// Give up on a hung core.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Present one sample, hold it until taken, then note it in the tracker.
	// Idle cycles go in front of the item so that valid never drops once raised.
	task automatic send_sample(input logic btn, input logic [31:0] t);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		button   <= btn;
		now_ms   <= t;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.take_sample(btn, t);
		n_sent++;
	endtask

	// Keep cfg_valid high across back-to-back writes; the caller drops it.
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// Drop valid and wait until every owed outcome is in, plus the pipeline depth.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.owed_outcomes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Load the registers for a phase: low extremes, high extremes, mixed extremes, then random.
	// Upper bits of the 16-bit registers carry junk that must be dropped.
	task automatic program_phase(input int unsigned p);
		logic [31:0] b;
		logic [31:0] w;
		logic [31:0] r;
		case (p)
			1: begin
				b = 0;
				w = 0;
				r = 0;
			end
			2: begin
				b = 32'hFFFF;
				w = 32'hFFFF;
				r = 32'hFFFF_FFFF;
			end
			3: begin
				b = 0;
				w = 32'hFFFF;
				r = 1;
			end
			default: begin
				b = $urandom_range(0, 120);
				w = $urandom_range(0, 900);
				r = (p == 5) ? $urandom() : $urandom_range(0, 4000);
			end
		endcase
		cfg_write(CFG_BOUNCE, b | ($urandom() & 32'hFFFF_0000));
		cfg_write(CFG_WINDOW, w | ($urandom() & 32'hFFFF_0000));
		cfg_write(CFG_RUN, r);
		if (p == 4)
			cfg_write(CFG_UNUSED, $urandom());
		cfg_valid <= 1'b0;
	endtask

	// Press length: mostly past the bounce time, often just past it, sometimes too short.
	function automatic logic [31:0] hold_len();
		logic [31:0] b;
		b = sb.bounce_ms;
		case ($urandom_range(0, 5))
			0:       return b;
			1:       return $urandom_range(0, b);
			2, 3:    return b + 1 + $urandom_range(0, 2);
			default: return b + 1 + $urandom_range(0, 300);
		endcase
	endfunction

	// One press and release, sometimes with a sample in the middle of the hold.
	task automatic tap(input logic [31:0] hold);
		send_sample(1'b1, t_ms);
		if ($urandom_range(0, 3) == 0)
			send_sample(1'b1, t_ms + hold / 2);
		t_ms = t_ms + hold;
		send_sample(1'b0, t_ms);
	endtask

	// Two taps with the release interval near or inside the window, then quiet.
	task automatic double_press();
		logic [31:0] w;
		logic [31:0] hold2;
		logic [31:0] ivl;
		w = sb.window_ms;
		t_ms = t_ms + $urandom_range(1, 2000);
		tap(hold_len());
		hold2 = hold_len();
		case ($urandom_range(0, 3))
			0:       ivl = w - 1;
			1:       ivl = w;
			default: ivl = hold2 + $urandom_range(0, (w > hold2 + 1) ? w - hold2 - 1 : 3);
		endcase
		if (ivl < hold2)
			ivl = hold2;
		t_ms = t_ms + ivl - hold2;
		tap(hold2);
		// Hit the quiet time on its edge first now and then.
		if ($urandom_range(0, 2) == 0)
			send_sample(1'b0, t_ms + w);
		t_ms = t_ms + w + 1 + (($urandom_range(0, 1) == 1) ? 0 : $urandom_range(0, 500));
		send_sample(1'b0, t_ms);
	endtask

	// Hold the button across the bounce time to switch the pump off.
	task automatic off_press();
		logic [31:0] b;
		b = sb.bounce_ms;
		t_ms = t_ms + $urandom_range(1, 50);
		send_sample(1'b1, t_ms);
		if ($urandom_range(0, 1) == 1)
			send_sample(1'b1, t_ms + b);
		t_ms = t_ms + b + $urandom_range(1, 3);
		send_sample(1'b1, t_ms);
		t_ms = t_ms + $urandom_range(1, 100);
		send_sample(1'b0, t_ms);
	endtask

	// Land on the run timer boundary, one short of it first now and then.
	task automatic run_to_timeout();
		if ($urandom_range(0, 1) == 1)
			send_sample(1'b0, sb.run_start + sb.run_ms - 1);
		t_ms = sb.run_start + sb.run_ms + $urandom_range(0, 1);
		send_sample($urandom_range(0, 1) == 1, t_ms);
	endtask

	task automatic run_scenario();
		logic [31:0] w;
		w = sb.window_ms;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				double_press();
				case ($urandom_range(0, 3))
					0: off_press();
					1: begin
						run_to_timeout();
						if ($urandom_range(0, 1) == 1)
							off_press();
					end
					// Double press again while armed, then switch off.
					2: begin
						double_press();
						off_press();
					end
					default: ;
				endcase
			end
			6, 7: begin
				tap(hold_len());
				t_ms = t_ms + $urandom_range(0, 2 * w + 2);
			end
			// Noise: random levels, small steps and wild jumps in time.
			default: begin
				repeat ($urandom_range(1, 6)) begin
					if ($urandom_range(0, 3) == 0)
						t_ms = $urandom();
					else
						t_ms = t_ms + $urandom_range(0, 2 * w + 2);
					send_sample($urandom_range(0, 1) == 1, t_ms);
				end
			end
		endcase
	endtask

	initial begin
		int unsigned start;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed samples at the reset settings.
		send_sample(1'b0, 32'h0);
		send_sample(1'b1, 32'hFFFF_FFFF);
		send_sample(1'b0, 32'd49);	// press only as long as the bounce time
		send_sample(1'b1, 32'd100);
		send_sample(1'b0, 32'd151);	// first release after reset counts as double
		send_sample(1'b0, 32'd551);	// quiet time exactly the window: not yet
		send_sample(1'b0, 32'd552);	// switch on
		send_sample(1'b1, 32'd600);
		send_sample(1'b0, 32'd640);
		send_sample(1'b1, 32'd700);	// double press while armed: ignored
		send_sample(1'b0, 32'd800);
		send_sample(1'b1, 32'd900);
		send_sample(1'b0, 32'd1000);
		send_sample(1'b0, 32'd600551);	// one short of the run time
		send_sample(1'b0, 32'd600552);	// timeout
		send_sample(1'b1, 32'd700000);
		send_sample(1'b1, 32'd700051);	// held press still fires after a timeout
		send_sample(1'b0, 32'd700100);
		send_sample(1'b1, 32'hFFFF_FF00);	// double press across the time wrap
		send_sample(1'b0, 32'hFFFF_FF40);
		send_sample(1'b1, 32'hFFFF_FFF0);
		send_sample(1'b0, 32'h0000_0030);
		send_sample(1'b0, 32'h0000_01C1);
		send_sample(1'b1, 32'h0000_0400);
		send_sample(1'b1, 32'h0000_0433);
		send_sample(1'b0, 32'h0000_0500);
		t_ms = 32'h0000_0500;

		// Random phases: each with its own settings and its own idling mix.
		for (int unsigned p = 0; p < PHASES; p++) begin
			if (p != 0) begin
				settle();
				program_phase(p);
			end
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
				1: begin
					send_idle_pct = 52;
					stall_pct     = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 52;
				end
				default: begin
					send_idle_pct = 13;
					stall_pct     = 13;
				end
			endcase
			start = n_sent;
			while (n_sent - start < ITEMS_PER_PHASE)
				run_scenario();
		end

		settle();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.owed_outcomes.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* sim.f */
hdl/bdp_pkg.sv
hdl/bdp_cfg.sv
hdl/bdp_step.sv
hdl/button_double_press_pump_timer_core.sv
tb/testbench.sv
